// ----- design/sha_pkg.sv -----
// Package: shared types and constants for the SHA-256 stream hasher
package sha_pkg;

   localparam int unsigned QueueDepth = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last_byte;
   } req_item_type;

   localparam logic [31:0] InitialHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ----- design/sha_req_queue.sv -----
// Front end: request queue, drops idle items
module sha_req_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sha_pkg::req_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sha_pkg::req_item_type out_item
);
   import sha_pkg::*;

   localparam int unsigned PtrW = $clog2(QueueDepth);

   req_item_type          mem [QueueDepth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]         count_ff, count_in;
   logic                  push, pop, keep;

   assign in_ready  = (count_ff != (PtrW+1)'(QueueDepth));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem[rd_ptr_ff];
   assign keep      = in_item.byte_present | in_item.last_byte;
   assign push      = in_valid & in_ready & keep;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end
endmodule

// ----- design/sha_core.sv -----
// Back end: block assembly, padding, round engine and digest output
module sha_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  sha_pkg::req_item_type item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [31:0]           out_word,
   output logic [2:0]            out_index,
   output logic                  out_last
);
   import sha_pkg::*;

   typedef enum logic [2:0] {
      ST_TAKE, ST_SCHED, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
   } state_type;

   state_type    state_ff;
   logic [31:0]  hash_ff [8];
   logic [31:0]  var_ff  [8];
   logic [31:0]  wsched_ff [16];
   logic [31:0]  blk_ff [16];   // message block, big-endian bytes per word
   logic [5:0]   fill_ff;
   logic [60:0]  count_ff;
   logic [5:0]   round_ff;
   logic [3:0]   load_ff;
   logic         final_ff;   // compressing a padding block
   logic         second_ff;  // another padding block follows
   logic [2:0]   emit_ff;

   logic [31:0] w15, w2, wnew, w_t, s0, s1, ch, maj, t1, t2;
   logic [31:0] pad_blk [16];
   logic [63:0] bits;

   assign item_ready = (state_ff == ST_TAKE);
   assign out_valid  = (state_ff == ST_EMIT);
   assign out_word   = hash_ff[emit_ff];
   assign out_index  = emit_ff;
   assign out_last   = (emit_ff == 3'd7);
   assign bits       = {count_ff, 3'b000};

   always_comb begin
      w15  = wsched_ff[round_ff[3:0] + 4'd1];
      w2   = wsched_ff[round_ff[3:0] + 4'd14];
      wnew = wsched_ff[round_ff[3:0]]
           + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3))
           + wsched_ff[round_ff[3:0] + 4'd9]
           + (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10));
      w_t  = (round_ff < 6'd16) ? wsched_ff[round_ff[3:0]] : wnew;
      s1   = ror32(var_ff[4], 6) ^ ror32(var_ff[4], 11) ^ ror32(var_ff[4], 25);
      ch   = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      t1   = var_ff[7] + s1 + ch + RoundK[round_ff] + w_t;
      s0   = ror32(var_ff[0], 2) ^ ror32(var_ff[0], 13) ^ ror32(var_ff[0], 22);
      maj  = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t2   = s0 + maj;
   end

   // padded block: 0x80 at fill_ff, zeros after it, length if it fits
   always_comb begin
      for (int w = 0; w < 16; w++) begin
         for (int b = 0; b < 4; b++) begin
            if ((4*w + b) == int'(fill_ff)) pad_blk[w][31-8*b -: 8] = 8'h80;
            else if ((4*w + b) > int'(fill_ff)) pad_blk[w][31-8*b -: 8] = 8'h00;
            else pad_blk[w][31-8*b -: 8] = blk_ff[w][31-8*b -: 8];
         end
      end
      if (fill_ff < 6'd56) begin
         pad_blk[14] = bits[63:32];
         pad_blk[15] = bits[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_TAKE;
         fill_ff   <= '0;
         count_ff  <= '0;
         round_ff  <= '0;
         load_ff   <= '0;
         final_ff  <= 1'b0;
         second_ff <= 1'b0;
         emit_ff   <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= InitialHash[i];
      end else begin
         case (state_ff)
            ST_TAKE: begin
               if (item_valid) begin
                  if (item.byte_present) begin
                     blk_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= item.data_byte;
                     fill_ff  <= fill_ff + 6'd1;
                     count_ff <= count_ff + 61'd1;
                  end
                  final_ff  <= 1'b0;
                  second_ff <= item.last_byte;
                  if (item.byte_present && fill_ff == 6'd63) begin
                     load_ff  <= '0;
                     state_ff <= ST_SCHED;
                  end else if (item.last_byte) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               for (int i = 0; i < 16; i++) blk_ff[i] <= pad_blk[i];
               second_ff <= (fill_ff >= 6'd56);
               final_ff <= 1'b1;
               load_ff  <= '0;
               state_ff <= ST_SCHED;
            end
            ST_SCHED: begin
               wsched_ff[load_ff] <= blk_ff[load_ff];
               load_ff <= load_ff + 4'd1;
               if (load_ff == 4'd15) begin
                  for (int i = 0; i < 8; i++) var_ff[i] <= hash_ff[i];
                  round_ff <= '0;
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               if (round_ff >= 6'd16) wsched_ff[round_ff[3:0]] <= wnew;
               var_ff[7] <= var_ff[6];
               var_ff[6] <= var_ff[5];
               var_ff[5] <= var_ff[4];
               var_ff[4] <= var_ff[3] + t1;
               var_ff[3] <= var_ff[2];
               var_ff[2] <= var_ff[1];
               var_ff[1] <= var_ff[0];
               var_ff[0] <= t1 + t2;
               round_ff  <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + var_ff[i];
               if (final_ff && second_ff) begin
                  // length-only block after an overflowing pad
                  for (int i = 0; i < 14; i++) blk_ff[i] <= 32'h0;
                  blk_ff[14] <= bits[63:32];
                  blk_ff[15] <= bits[31:0];
                  second_ff <= 1'b0;
                  load_ff   <= '0;
                  state_ff  <= ST_SCHED;
               end else if (final_ff) begin
                  emit_ff  <= '0;
                  state_ff <= ST_EMIT;
               end else if (second_ff) begin
                  state_ff <= ST_PAD;
               end else begin
                  state_ff <= ST_TAKE;
               end
            end
            ST_EMIT: begin
               if (out_ready) begin
                  emit_ff <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) hash_ff[i] <= InitialHash[i];
                     fill_ff  <= '0;
                     count_ff <= '0;
                     final_ff <= 1'b0;
                     state_ff <= ST_TAKE;
                  end
               end
            end
            default: state_ff <= ST_TAKE;
         endcase
      end
   end
endmodule

// ----- design/sha256_stream_hasher.sv -----
// Top level: SHA-256 hasher over a byte request stream
//
//  channel | dir | tdata                      | tuser        | tlast
//  req     | in  | data_byte[7:0]             | byte_present | last_byte
//  rsp     | out | digest_word[31:0]          | word_index   | last_word
//
// A byte request is written into the block by the core; every 64th byte adds a
// schedule load, the compression rounds and a fold on the single round unit.
// End of message adds a pad step and one or two compressions, then eight
// digest words. A four-entry queue keeps accepting requests while the core works,
// until it is full. Reset clears the queue and restores the initial hash values.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast    // last_word
);
   import sha_pkg::*;

   req_item_type in_item, q_item;
   logic         q_valid, q_ready;

   assign in_item = '{data_byte: req_tdata, byte_present: req_tuser, last_byte: req_tlast};

   sha_req_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   sha_core u_core (
      .clock(clock), .reset(reset),
      .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(rsp_tdata), .out_index(rsp_tuser), .out_last(rsp_tlast)
   );

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 3'd7)))
      else $error("last flag mismatch");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 3'd1))
      else $error("digest index skipped");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("digest word changed while stalled");
endmodule
